@@ rtl/window_pixel_unpacker_assert.svh @@
// Assertion macros for the window pixel unpacker.
// Each macro expects a clock named clk and a synchronous reset named rst at the point of use.
`ifndef WINDOW_PIXEL_UNPACKER_ASSERT_SVH
`define WINDOW_PIXEL_UNPACKER_ASSERT_SVH

`define WPU_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("window_pixel_unpacker invariant violated");

`define WPU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window_pixel_unpacker implication violated");

`define WPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window_pixel_unpacker next-cycle check violated");

`endif

@@ rtl/wpu_pkg.sv @@
// Package for the window pixel unpacker: register indexes, codes and depth helpers.
// Has no dependencies; used by window_pixel_unpacker.
`default_nettype none

package wpu_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_PIXEL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PACK_MODE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BYTES    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT  = 3'd4;

  localparam logic [1:0] PACK_INDEPENDENT = 2'd0;
  localparam logic [1:0] PACK_ROW         = 2'd1;
  localparam logic [1:0] PACK_COLUMN      = 2'd2;

  localparam logic REQ_WINDOW = 1'b0;
  localparam logic REQ_DATA   = 1'b1;

  localparam logic [4:0] BPP_1  = 5'd1;
  localparam logic [4:0] BPP_2  = 5'd2;
  localparam logic [4:0] BPP_4  = 5'd4;
  localparam logic [4:0] BPP_8  = 5'd8;
  localparam logic [4:0] BPP_16 = 5'd16;
  localparam logic [4:0] BPP_24 = 5'd24;

  localparam logic [4:0]  BPP_RESET      = BPP_1;
  localparam logic [7:0]  CHUNK_RESET    = 8'd63;
  localparam logic [15:0] SCREEN_W_RESET = 16'd128;
  localparam logic [15:0] SCREEN_H_RESET = 16'd64;

  function automatic logic depth_valid(input logic [4:0] d);
    logic ok;
    case (d)
      BPP_1, BPP_2, BPP_4, BPP_8, BPP_16, BPP_24: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Log2 of the pixels per byte below 8 bits, zero otherwise.
  function automatic logic [1:0] pix_shift(input logic [4:0] d);
    logic [1:0] s;
    case (d)
      BPP_1: s = 2'd3;
      BPP_2: s = 2'd2;
      BPP_4: s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] bytes_per_pixel(input logic [4:0] d);
    logic [1:0] n;
    case (d)
      BPP_16: n = 2'd2;
      BPP_24: n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/window_pixel_unpacker.sv @@
// Window pixel unpacker: an input register, single-pass unpack logic and a result register.
// Depends on wpu_pkg and the assertion macros in window_pixel_unpacker_assert.svh.
//
// A window start steps through operand setup, a multiply and rounding, and gives no
// result. A data byte yields one pixel per cycle while the result register can take it:
// 8/depth pixels below 8 bits in independent mode and at most one otherwise. The result
// register lets a new transaction enter while the previous result waits on m_tready. A write
// of chunk_bytes starts a bit-serial remainder pass that rebuilds the chunk position,
// during which s_tready stays low. Configuration writes are taken only while no item is held.
`default_nettype none
`include "window_pixel_unpacker_assert.svh"

module window_pixel_unpacker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // win_x[15:0], win_y[31:16], win_w[47:32], win_h[63:48], data_byte[71:64]
  input  logic [71:0]                     s_tdata,
  // req_type[0]
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_x[15:0], pixel_y[31:16], colour[55:32], draw_enable[56], chunk_ack[57],
  // window_done[58], zero[63:59]
  output logic [63:0]                     m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wpu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wpu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wpu_pkg::*;

  typedef enum logic [1:0] {HDR_OPERANDS, HDR_MULTIPLY, HDR_FINISH} hdr_phase_t;

  logic [4:0]  bits_per_pixel;
  logic [1:0]  pack_mode;
  logic [7:0]  chunk_bytes;
  logic [15:0] screen_width;
  logic [15:0] screen_height;

  logic        item_valid;
  logic        item_type;
  logic [15:0] item_x, item_y, item_w, item_h;
  logic [7:0]  item_byte;
  logic [2:0]  sub_index;
  hdr_phase_t  hdr_phase;

  logic        active;
  logic [15:0] origin_x, origin_y;
  logic [16:0] end_x, end_y;
  logic [15:0] cursor_x, cursor_y;
  logic [31:0] total_bytes, bytes_done;
  logic [7:0]  chunk_position;
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  logic [15:0] op_a;
  logic [17:0] op_b;
  logic [33:0] product;

  logic        rem_busy;
  logic [4:0]  rem_count;

  logic        out_valid;
  logic [15:0] out_x, out_y;
  logic [23:0] out_colour;
  logic        out_draw, out_ack, out_done, out_last;

  logic [1:0]  mode_eff;
  logic        low_depth;
  logic [1:0]  shift;
  logic [1:0]  dlog;
  logic [3:0]  pix_step;
  logic [1:0]  bpb;
  logic [8:0]  ceff;
  logic        is_hdr;
  logic        gate;
  logic [31:0] after;
  logic        last_byte;
  logic        slot_free;
  logic        gather_done;
  logic        emits;
  logic        sub_last;
  logic        fire;
  logic        consume;
  logic [2:0]  sub_shift;
  logic [7:0]  low_mask;
  logic [23:0] colour;
  logic        draw;
  logic [1:0]  pj;
  logic [1:0]  pj_mod;
  logic        pstart_hit;
  logic        ack;
  logic [15:0] row_dx;
  logic [15:0] row_x;
  logic [15:0] col_y;
  logic [15:0] cursor_x_next, cursor_y_next;
  logic [8:0]  pos_inc;
  logic [7:0]  pos_next;
  logic [8:0]  rem_trial;
  logic [16:0] ceil_w, ceil_h;
  logic [17:0] h_times;
  logic [32:0] rounded;
  logic [31:0] total_next;

  always_comb begin
    mode_eff  = (pack_mode == PACK_ROW || pack_mode == PACK_COLUMN) ? pack_mode
                                                                    : PACK_INDEPENDENT;
    low_depth = bits_per_pixel < BPP_8;
    shift     = pix_shift(bits_per_pixel);
    dlog      = 2'd3 - shift;
    pix_step  = 4'(4'd1 << shift);
    bpb       = bytes_per_pixel(bits_per_pixel);
    ceff      = (chunk_bytes == 8'd0) ? 9'd256 : {1'b0, chunk_bytes};
    is_hdr    = item_type == REQ_WINDOW;
    gate      = active && (bytes_done < total_bytes);
    after     = bytes_done + 32'd1;
    last_byte = after == total_bytes;
    slot_free = !out_valid || m_tready;
    gather_done = ({1'b0, held_count} + 3'd1) >= {1'b0, bpb};
    emits     = low_depth || gather_done;
    sub_last  = !low_depth || mode_eff != PACK_INDEPENDENT ||
                sub_index == 3'(pix_step - 4'd1);
    fire      = item_valid && !is_hdr && gate && emits && slot_free;
    if (is_hdr) begin
      consume = item_valid && hdr_phase == HDR_FINISH;
    end else begin
      consume = item_valid && (!gate || !emits || (fire && sub_last));
    end

    sub_shift = sub_index << dlog;
    low_mask  = 8'((9'd1 << bits_per_pixel) - 9'd1);
    if (!low_depth) begin
      colour = {held_bytes, item_byte};
    end else if (mode_eff == PACK_INDEPENDENT) begin
      colour = {16'd0, (item_byte >> sub_shift) & low_mask};
    end else begin
      colour = {16'd0, item_byte};
    end
    draw = low_depth || (cursor_x < screen_width && cursor_y < screen_height);

    // The first byte of the pixel lies pj bytes back; its chunk test reduces to a compare.
    pj = bpb - 2'd1;
    case (pj)
      2'd1: pj_mod = (ceff == 9'd1) ? 2'd0 : 2'd1;
      2'd2: pj_mod = (ceff == 9'd1 || ceff == 9'd2) ? 2'd0 : 2'd2;
      default: pj_mod = 2'd0;
    endcase
    pstart_hit = (bytes_done < {30'd0, pj}) || (chunk_position == {6'd0, pj_mod});
    if (low_depth) begin
      ack = (chunk_position == 8'd0) && !last_byte;
    end else begin
      ack = pstart_hit && ((total_bytes - after) >= {23'd0, ceff});
    end

    row_dx = (low_depth && mode_eff == PACK_ROW) ? {12'd0, pix_step} : 16'd1;
    row_x  = cursor_x + row_dx;
    col_y  = cursor_y + {12'd0, pix_step};
    if (low_depth && mode_eff == PACK_COLUMN) begin
      if ({1'b0, col_y} >= end_y) begin
        cursor_x_next = cursor_x + 16'd1;
        cursor_y_next = origin_y;
      end else begin
        cursor_x_next = cursor_x;
        cursor_y_next = col_y;
      end
    end else if ({1'b0, row_x} >= end_x) begin
      cursor_x_next = origin_x;
      cursor_y_next = cursor_y + 16'd1;
    end else begin
      cursor_x_next = row_x;
      cursor_y_next = cursor_y;
    end

    pos_inc  = {1'b0, chunk_position} + 9'd1;
    pos_next = (pos_inc == ceff) ? 8'd0 : pos_inc[7:0];
    rem_trial = {chunk_position, bytes_done[~rem_count]};

    ceil_w  = ({1'b0, item_w} + {13'd0, pix_step - 4'd1}) >> shift;
    ceil_h  = ({1'b0, item_h} + {13'd0, pix_step - 4'd1}) >> shift;
    case (bpb)
      2'd2: h_times = {1'b0, item_h, 1'b0};
      2'd3: h_times = {1'b0, item_h, 1'b0} + {2'd0, item_h};
      default: h_times = {2'd0, item_h};
    endcase
    rounded = ({1'b0, product[31:0]} + {29'd0, pix_step - 4'd1}) >> shift;
    if (low_depth && mode_eff == PACK_INDEPENDENT) begin
      total_next = rounded[31:0];
    end else if (product[33:32] != 2'd0) begin
      total_next = 32'hFFFF_FFFF;
    end else begin
      total_next = product[31:0];
    end

    s_tready  = !rem_busy && (!item_valid || consume);
    cfg_ready = !item_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= BPP_RESET;
      pack_mode      <= PACK_INDEPENDENT;
      chunk_bytes    <= CHUNK_RESET;
      screen_width   <= SCREEN_W_RESET;
      screen_height  <= SCREEN_H_RESET;
      item_valid     <= 1'b0;
      sub_index      <= 3'd0;
      hdr_phase      <= HDR_OPERANDS;
      active         <= 1'b0;
      origin_x       <= 16'd0;
      origin_y       <= 16'd0;
      end_x          <= 17'd0;
      end_y          <= 17'd0;
      cursor_x       <= 16'd0;
      cursor_y       <= 16'd0;
      total_bytes    <= 32'd0;
      bytes_done     <= 32'd0;
      chunk_position <= 8'd0;
      held_bytes     <= 16'd0;
      held_count     <= 2'd0;
      rem_busy       <= 1'b0;
      rem_count      <= 5'd0;
      out_valid      <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        item_valid <= 1'b1;
      end else if (consume) begin
        item_valid <= 1'b0;
      end

      if (item_valid && is_hdr) begin
        case (hdr_phase)
          HDR_OPERANDS: hdr_phase <= HDR_MULTIPLY;
          HDR_MULTIPLY: hdr_phase <= HDR_FINISH;
          default: begin
            hdr_phase      <= HDR_OPERANDS;
            origin_x       <= item_x;
            origin_y       <= item_y;
            end_x          <= {1'b0, item_x} + {1'b0, item_w};
            end_y          <= {1'b0, item_y} + {1'b0, item_h};
            cursor_x       <= item_x;
            cursor_y       <= item_y;
            total_bytes    <= total_next;
            bytes_done     <= 32'd0;
            chunk_position <= 8'd0;
            held_bytes     <= 16'd0;
            held_count     <= 2'd0;
            active         <= total_next != 32'd0;
          end
        endcase
      end

      if (fire) begin
        cursor_x  <= cursor_x_next;
        cursor_y  <= cursor_y_next;
        sub_index <= sub_last ? 3'd0 : sub_index + 3'd1;
      end

      if (consume && !is_hdr && gate) begin
        bytes_done     <= after;
        chunk_position <= pos_next;
        if (last_byte || gather_done) begin
          held_bytes <= 16'd0;
          held_count <= 2'd0;
        end else if (!low_depth) begin
          held_bytes <= {held_bytes[7:0], item_byte};
          held_count <= held_count + 2'd1;
        end
        if (last_byte) begin
          active <= 1'b0;
        end
      end

      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (rem_busy) begin
        chunk_position <= (rem_trial >= ceff) ? 8'(rem_trial - ceff) : rem_trial[7:0];
        rem_count      <= rem_count + 5'd1;
        if (rem_count == 5'd31) begin
          rem_busy <= 1'b0;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BITS_PER_PIXEL: begin
            if (depth_valid(cfg_data[4:0])) begin
              bits_per_pixel <= cfg_data[4:0];
            end
          end
          REG_PACK_MODE: pack_mode <= cfg_data[1:0];
          REG_CHUNK_BYTES: begin
            chunk_bytes    <= cfg_data[7:0];
            chunk_position <= 8'd0;
            rem_busy       <= 1'b1;
            rem_count      <= 5'd0;
          end
          REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_type <= s_tuser[0];
      item_x    <= s_tdata[15:0];
      item_y    <= s_tdata[31:16];
      item_w    <= s_tdata[47:32];
      item_h    <= s_tdata[63:48];
      item_byte <= s_tdata[71:64];
    end
    if (item_valid && is_hdr && hdr_phase == HDR_OPERANDS) begin
      op_a <= item_w;
      op_b <= {2'd0, item_h};
      if (low_depth && mode_eff == PACK_ROW) begin
        op_a <= ceil_w[15:0];
      end else if (low_depth && mode_eff == PACK_COLUMN) begin
        op_b <= {1'b0, ceil_h};
      end else if (!low_depth) begin
        op_b <= h_times;
      end
    end
    if (item_valid && is_hdr && hdr_phase == HDR_MULTIPLY) begin
      product <= {18'd0, op_a} * {16'd0, op_b};
    end
    if (fire) begin
      out_x      <= cursor_x;
      out_y      <= cursor_y;
      out_colour <= colour;
      out_draw   <= draw;
      out_ack    <= sub_last && ack;
      out_done   <= sub_last && last_byte;
      out_last   <= sub_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_done, out_ack, out_draw, out_colour, out_y, out_x};
  assign m_tlast  = out_last;

  `WPU_ASSERT_ALWAYS(a_chunk_pos_range, {1'b0, chunk_position} < ceff)
  `WPU_ASSERT_IMPLY(a_held_clear_idle, !active, held_count == 2'd0)
  `WPU_ASSERT_IMPLY(a_done_on_last, out_valid && out_done, out_last)
  `WPU_ASSERT_IMPLY(a_rem_blocks_input, rem_busy, !s_tready)
  `WPU_ASSERT_NEXT(a_chunk_write_starts_rem,
                   cfg_valid && cfg_ready && cfg_index == REG_CHUNK_BYTES, rem_busy)

endmodule

`default_nettype wire
